FILE: src/rvce_pkg.sv
// Shared types and constants for the RIFF VP8 chunk extractor.
`default_nettype none

package rvce_pkg;

    // Width of the file length register and the byte position counter.
    localparam int LENGTH_BITS = 32;
    // Width of the sum used in the chunk overrun check.
    localparam int SUM_W = 34;

    localparam logic [31:0] SIG_RIFF = 32'h5249_4646;
    localparam logic [31:0] SIG_WEBP = 32'h5745_4250;
    localparam logic [31:0] SIG_VP8  = 32'h5650_3820;

    localparam int FILE_HEADER_BYTES  = 12;
    localparam int CHUNK_HEADER_BYTES = 8;

    // Packed width of the result bus: payload byte, length and error code.
    localparam int TDATA_W = 48;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_SIGNATURE = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_PAD       = 2'd2;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd3;

    typedef enum logic [5:0] {
        PH_HEADER    = 6'b000001,
        PH_CHUNK_HDR = 6'b000010,
        PH_SKIP      = 6'b000100,
        PH_PAD       = 6'b001000,
        PH_PAYLOAD   = 6'b010000,
        PH_DONE      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] payload_length;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/rvce_parser.sv
// Parser state and the per-byte next-state and result logic.
`default_nettype none

module rvce_parser
    import rvce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [31:0] cfg_value,
    input  wire logic        byte_fire,
    input  wire logic [7:0]  data_byte,
    output logic             res_valid,
    output result_t          res
);

    logic [LENGTH_BITS-1:0] file_length_reg;
    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [63:0]            shift_reg, shift_next;
    logic [31:0]            rem_reg, rem_next;
    logic                   sig_reg, sig_next;
    logic [31:0]            found_reg, found_next;

    logic                   at_end;
    logic [63:0]            shift_in;
    logic [31:0]            rem_dec;
    logic [31:0]            clen;
    logic                   overrun;
    logic                   pay_last;

    assign at_end   = ({1'b0, pos_reg} + {{LENGTH_BITS{1'b0}}, 1'b1}) >= {1'b0, file_length_reg};
    assign shift_in = {shift_reg[55:0], data_byte};
    assign rem_dec  = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;
    // The chunk length field is little-endian.
    assign clen     = {shift_in[7:0], shift_in[15:8], shift_in[23:16], shift_in[31:24]};
    assign overrun  = (SUM_W'(pos_reg) + SUM_W'(clen) + SUM_W'(1)) > SUM_W'(file_length_reg);
    assign pay_last = (rem_dec == 32'd0) || at_end;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        sig_next   = sig_reg;
        found_next = found_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (file_length_reg < LENGTH_BITS'(FILE_HEADER_BYTES))
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.error_code = ERR_SIGNATURE;
                    res.last   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    shift_next = shift_in;
                    if (pos_reg == LENGTH_BITS'(3) && shift_in[31:0] != SIG_RIFF)
                    begin
                        sig_next = 1'b0;
                    end
                    if (pos_reg == LENGTH_BITS'(11))
                    begin
                        if (!sig_reg || shift_in[31:0] != SIG_WEBP)
                        begin
                            sig_next   = 1'b0;
                            res_valid  = 1'b1;
                            res.kind   = KIND_ERROR;
                            res.error_code = ERR_SIGNATURE;
                            res.last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_HDR;
                            rem_next   = 32'(CHUNK_HEADER_BYTES);
                            shift_next = '0;
                        end
                    end
                end
            end
            PH_CHUNK_HDR:
            begin
                shift_next = shift_in;
                rem_next   = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    found_next = clen;
                    if (overrun)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERROR;
                        res.error_code = ERR_OVERRUN;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (shift_in[63:32] == SIG_VP8)
                    begin
                        if (clen == 32'd0)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_EMPTY;
                            res.last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            rem_next   = clen;
                        end
                    end
                    else if (clen == 32'd0)
                    begin
                        phase_next = PH_CHUNK_HDR;
                        rem_next   = 32'(CHUNK_HEADER_BYTES);
                        shift_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        rem_next   = clen;
                    end
                end
            end
            PH_SKIP:
            begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0)
                begin
                    if (found_reg[0])
                    begin
                        phase_next = PH_PAD;
                    end
                    else
                    begin
                        phase_next = PH_CHUNK_HDR;
                        rem_next   = 32'(CHUNK_HEADER_BYTES);
                        shift_next = '0;
                    end
                end
            end
            PH_PAD:
            begin
                phase_next = PH_CHUNK_HDR;
                rem_next   = 32'(CHUNK_HEADER_BYTES);
                shift_next = '0;
            end
            PH_PAYLOAD:
            begin
                rem_next           = rem_dec;
                res_valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.payload_byte   = data_byte;
                res.payload_length = found_reg;
                res.last           = pay_last;
                if (pay_last)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (at_end)
        begin
            // The file ends here; report why if nothing has ended it yet.
            if (!res_valid && phase_next != PH_DONE)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_ERROR;
                res.last  = 1'b1;
                case (phase_next)
                    PH_HEADER: res.error_code = ERR_SIGNATURE;
                    PH_SKIP:   res.error_code = ERR_OVERRUN;
                    PH_PAD:    res.error_code = ERR_PAD;
                    default:   res.error_code = ERR_NOT_FOUND;
                endcase
            end
            phase_next = PH_HEADER;
            pos_next   = '0;
            shift_next = '0;
            rem_next   = '0;
            sig_next   = 1'b1;
            found_next = '0;
        end
        else
        begin
            pos_next = pos_reg + LENGTH_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= LENGTH_BITS'(FILE_HEADER_BYTES);
        end
        else if (cfg_write)
        begin
            file_length_reg <= cfg_value[LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            sig_reg   <= 1'b1;
            found_reg <= '0;
        end
        else if (byte_fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            sig_reg   <= sig_next;
            found_reg <= found_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/rvce_out_reg.sv
// Result register that holds one result until the downstream side takes it.
`default_nettype none

module rvce_out_reg
    import rvce_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      out_data,
    output logic         slot_free
);

    logic    valid_reg;
    result_t data_reg;

    // A new result may enter when the register is empty or drains this cycle.
    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/riff_vp8_chunk_extractor.sv
// Top level of the RIFF container VP8 chunk extractor.
//
//  channel   direction  signals                              transfer
//  s_axis    in         tvalid tready tdata[7:0]             one container byte
//  m_axis    out        tvalid tready tdata[47:0] tuser tlast  one result
//  cfg       in         cfg_valid cfg_ready cfg_data[31:0]   file length write
//
// Each input byte is parsed in the cycle it transfers, and its result, if any,
// sits in the output register from the next cycle on.
// One byte per cycle is sustained while the output register drains each cycle.
// s_axis_tready drops only while a result waits in the output register.
// Reset clears the parser to the start of a file and sets the file length to 12.
`default_nettype none

module riff_vp8_chunk_extractor
    import rvce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] payload_byte, [39:8] payload_length, [41:40] error_code, rest zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]              m_axis_tuser,   // [1:0] result_kind
    output logic                    m_axis_tlast,   // last_result
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data        // file_length
);

    logic    byte_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    slot_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = slot_free;
    assign byte_fire     = s_axis_tvalid && slot_free;

    rvce_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_value (cfg_data),
        .byte_fire (byte_fire),
        .data_byte (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    rvce_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (byte_fire && res_valid),
        .load_data (res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .slot_free (slot_free)
    );

    assign m_axis_tdata = {6'd0, out_res.error_code, out_res.payload_length,
                           out_res.payload_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: bench/tb_riff_vp8_chunk_extractor.sv
// Self-checking testbench for the RIFF container VP8 chunk extractor.
`timescale 1ns / 1ps

module tb_riff_vp8_chunk_extractor
    import rvce_pkg::*;
();

    localparam int ITEM_TARGET = 1650;

    // Parses the container byte by byte alongside the block and holds the
    // results it should produce, oldest first.
    class vp8_extract_scoreboard;
        bit [31:0] file_len;
        phase_t    phase;
        bit [31:0] pos;
        bit [63:0] shift;
        bit [31:0] remaining;
        bit        sig_ok;
        bit [31:0] chunk_len;
        result_t   expected_q[$];
        int        mismatches;
        int        kind_seen[3];
        int        code_seen[4];

        function new();
            file_len = 32'd12;
            restart();
        endfunction

        function void restart();
            phase = PH_HEADER;
            pos = '0;
            shift = '0;
            remaining = '0;
            sig_ok = 1'b1;
            chunk_len = '0;
        endfunction

        function void open_chunk_header();
            phase = PH_CHUNK_HDR;
            remaining = CHUNK_HEADER_BYTES;
            shift = '0;
        endfunction

        function result_t error_result(logic [1:0] code);
            result_t r;
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = code;
            r.last = 1'b1;
            return r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit at_file_start();
            return pos == 0 && phase == PH_HEADER;
        endfunction

        function void note_byte(logic [7:0] b);
            bit [63:0] next_pos;
            bit [63:0] end_pos;
            bit [31:0] lo;
            bit [31:0] clen;
            bit        at_end;
            bit        have;
            result_t   r;
            next_pos = {32'd0, pos} + 64'd1;
            end_pos = {32'd0, file_len};
            at_end = next_pos >= end_pos;
            have = 1'b0;
            r = '0;
            case (phase)
                PH_HEADER: begin
                    if (file_len < FILE_HEADER_BYTES) begin
                        r = error_result(ERR_SIGNATURE);
                        have = 1'b1;
                        phase = PH_DONE;
                    end else begin
                        shift = {shift[55:0], b};
                        if (pos == 3 && shift[31:0] != SIG_RIFF)
                            sig_ok = 1'b0;
                        if (pos == 11) begin
                            if (shift[31:0] != SIG_WEBP)
                                sig_ok = 1'b0;
                            if (!sig_ok) begin
                                r = error_result(ERR_SIGNATURE);
                                have = 1'b1;
                                phase = PH_DONE;
                            end else begin
                                open_chunk_header();
                            end
                        end
                    end
                end
                PH_CHUNK_HDR: begin
                    shift = {shift[55:0], b};
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0) begin
                        lo = shift[31:0];
                        // The length field arrives least significant byte first.
                        clen = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
                        chunk_len = clen;
                        if (next_pos + {32'd0, clen} > end_pos) begin
                            r = error_result(ERR_OVERRUN);
                            have = 1'b1;
                            phase = PH_DONE;
                        end else if (shift[63:32] == SIG_VP8) begin
                            if (clen == 0) begin
                                r.kind = KIND_EMPTY;
                                r.last = 1'b1;
                                have = 1'b1;
                                phase = PH_DONE;
                            end else begin
                                phase = PH_PAYLOAD;
                                remaining = clen;
                            end
                        end else if (clen == 0) begin
                            open_chunk_header();
                        end else begin
                            phase = PH_SKIP;
                            remaining = clen;
                        end
                    end
                end
                PH_SKIP: begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0) begin
                        if (chunk_len[0])
                            phase = PH_PAD;
                        else
                            open_chunk_header();
                    end
                end
                PH_PAD: open_chunk_header();
                PH_PAYLOAD: begin
                    if (remaining != 0)
                        remaining--;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.payload_length = chunk_len;
                    r.last = (remaining == 0) || at_end;
                    have = 1'b1;
                    if (r.last)
                        phase = PH_DONE;
                end
                default: phase = PH_DONE;
            endcase

            if (at_end) begin
                // A file that ends with nothing reported yet reports why here.
                if (!have && phase != PH_DONE) begin
                    case (phase)
                        PH_HEADER: r = error_result(ERR_SIGNATURE);
                        PH_SKIP:   r = error_result(ERR_OVERRUN);
                        PH_PAD:    r = error_result(ERR_PAD);
                        default:   r = error_result(ERR_NOT_FOUND);
                    endcase
                    have = 1'b1;
                end
                restart();
            end else begin
                pos = next_pos[31:0];
            end
            if (have)
                expected_q.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [1:0] kind, logic [TDATA_W-1:0] data, logic last);
            result_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result kind %0d data %h last %0b", kind, data, last));
                return;
            end
            want = expected_q.pop_front();
            if (want.kind <= KIND_ERROR)
                kind_seen[want.kind]++;
            if (want.kind == KIND_ERROR)
                code_seen[want.error_code]++;
            if (kind !== want.kind || data[7:0] !== want.payload_byte
                    || data[39:8] !== want.payload_length
                    || data[41:40] !== want.error_code
                    || data[TDATA_W-1:42] !== '0 || last !== want.last)
                flag($sformatf({"expected kind %0d byte %h length %h code %0d last %0b, ",
                                "got kind %0d byte %h length %h code %0d last %0b pad %h"},
                               want.kind, want.payload_byte, want.payload_length,
                               want.error_code, want.last, kind, data[7:0], data[39:8],
                               data[41:40], last, data[TDATA_W-1:42]));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;    // [7:0] data_byte
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [7:0] payload_byte, [39:8] payload_length, [41:40] error_code, rest zero
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [1:0]         m_axis_tuser;    // [1:0] result_kind
    logic               m_axis_tlast;    // last_result
    logic               cfg_valid;
    logic               cfg_ready;
    logic [31:0]        cfg_data;        // file_length

    vp8_extract_scoreboard sb;
    bit [7:0] image[$];
    int bytes_sent;
    int length_writes;
    int sender_idle_pct;
    int receiver_stall_pct;

    riff_vp8_chunk_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                sb.file_len = cfg_data;
                length_writes++;
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    function void put_be32(bit [31:0] w);
        image.push_back(w[31:24]);
        image.push_back(w[23:16]);
        image.push_back(w[15:8]);
        image.push_back(w[7:0]);
    endfunction

    function void put_le32(bit [31:0] w);
        image.push_back(w[7:0]);
        image.push_back(w[15:8]);
        image.push_back(w[23:16]);
        image.push_back(w[31:24]);
    endfunction

    task automatic send_byte(logic [7:0] b);
        // The run moves through quiet, sender-idle, receiver-stall and mixed stretches.
        case (bytes_sent * 4 / ITEM_TARGET)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 61; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 61; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
        endcase
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_image(int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(image[i]);
        image.delete();
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        // The monitor notes the last transfer at the edge just passed, so look
        // at the expected queue only after another edge.
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // Bytes that produce no result leave nothing in the queue to wait on, so the
        // bus idles on before the register is touched.
        repeat (4) @(posedge clk);
    endtask

    task automatic set_file_length(bit [31:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Leftovers of an abandoned file are flushed by shrinking the length to one.
    task automatic seek_file_start();
        settle();
        if (!sb.at_file_start()) begin
            set_file_length(32'd1);
            send_byte($urandom_range(0, 255));
        end
    endtask

    task automatic run_container();
        int unsigned chunks;
        int unsigned vp8_slot;
        int unsigned i;
        int unsigned total;
        int unsigned flen;
        int unsigned extra;
        int unsigned where;
        bit [31:0]   id;
        bit [31:0]   clen;
        bit          huge;
        image.delete();
        put_be32(SIG_RIFF);
        put_le32($urandom());
        put_be32(SIG_WEBP);
        chunks = $urandom_range(0, 4);
        // A slot past the last chunk leaves the file without a VP8 chunk.
        vp8_slot = $urandom_range(0, chunks + 1);
        for (i = 0; i < chunks; i++) begin
            case ($urandom_range(0, 3))
                0: id = SIG_VP8 ^ (32'd1 << $urandom_range(0, 31));
                1: id = 32'h5650_384C;
                2: id = 32'h414C_5048;
                default: id = $urandom();
            endcase
            if (i == vp8_slot)
                id = SIG_VP8;
            huge = ($urandom_range(0, 19) == 0);
            if (huge)
                clen = $urandom();
            else if ($urandom_range(0, 4) == 0)
                clen = 0;
            else
                clen = $urandom_range(1, 9);
            put_be32(id);
            put_le32(clen);
            if (huge)
                break;
            repeat (clen + clen % 2) image.push_back($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            where = $urandom_range(0, 7);
            where = (where < 4) ? where : where + 4;
            image[where] ^= 8'd1 << $urandom_range(0, 7);
        end
        total = image.size();
        case ($urandom_range(0, 9))
            0, 1, 2: flen = $urandom_range(1, total);
            3: begin
                extra = $urandom_range(1, 12);
                flen = total + extra;
                repeat (extra) image.push_back($urandom_range(0, 255));
            end
            default: flen = total;
        endcase
        set_file_length(flen);
        send_image(flen);
    endtask

    // A large declared length lets a long chunk start; the length is then
    // rewritten to cut the file short one to three bytes later.
    task automatic run_long_payload();
        bit [31:0]   flen;
        bit [31:0]   clen;
        bit [31:0]   cut;
        int unsigned k;
        flen = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom() | 32'h0000_0040);
        clen = $urandom_range(1, flen - 20);
        image.delete();
        put_be32(SIG_RIFF);
        put_le32($urandom());
        put_be32(SIG_WEBP);
        put_be32(($urandom_range(0, 3) == 0) ? 32'h414C_5048 : SIG_VP8);
        put_le32(clen);
        repeat ($urandom_range(1, 6)) image.push_back($urandom_range(0, 255));
        set_file_length(flen);
        send_image(image.size());
        k = $urandom_range(0, 2);
        settle();
        cut = sb.pos + 1 + k;
        set_file_length(cut);
        repeat (k + 1) send_byte($urandom_range(0, 255));
    endtask

    task automatic run_noise();
        int unsigned flen;
        int unsigned n;
        flen = $urandom_range(0, 24);
        n = (flen == 0) ? $urandom_range(1, 3) : $urandom_range(1, flen);
        set_file_length(flen);
        repeat (n) send_byte($urandom_range(0, 255));
    endtask

    initial begin
        int unsigned pick;
        int guard;
        sb = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Under the reset length of 12, a bare header with no chunks.
        put_be32(SIG_RIFF);
        put_le32(32'd4);
        put_be32(SIG_WEBP);
        send_image(12);
        // A zero length makes every byte a short file of its own.
        set_file_length(32'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        set_file_length(32'd1);
        send_byte(8'h5A);

        while (bytes_sent < ITEM_TARGET) begin
            seek_file_start();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_container();
            else if (pick < 80)
                run_long_payload();
            else
                run_noise();
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));

        $display("Sent %0d container bytes under %0d length writes; checked %0d payload bytes,",
                 bytes_sent, length_writes, sb.kind_seen[KIND_PAYLOAD]);
        $display("%0d empty markers and errors by code %0d/%0d/%0d/%0d; %0d mismatches.",
                 sb.kind_seen[KIND_EMPTY], sb.code_seen[ERR_SIGNATURE],
                 sb.code_seen[ERR_OVERRUN], sb.code_seen[ERR_PAD],
                 sb.code_seen[ERR_NOT_FOUND], sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/rvce_pkg.sv
src/rvce_parser.sv
src/rvce_out_reg.sv
src/riff_vp8_chunk_extractor.sv
bench/tb_riff_vp8_chunk_extractor.sv
